### hw/rtl/rrace_pkg.sv
// Package: operation codes, FSM states and shared types for the region engine.
package rrace_pkg;

  typedef enum logic [2:0] {
    FUNC_ADD   = 3'd0,
    FUNC_CUT   = 3'd1,
    FUNC_QUERY = 3'd2,
    FUNC_MOVE  = 3'd3,
    FUNC_PURGE = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_PEND_RD,
    ST_INS_SRCH,
    ST_INS_SELF,
    ST_QOUT,
    ST_DONE
  } state_e;

endpackage

### hw/rtl/rrace_slot_mem.sv
// Slot rectangle memory: one write port, one registered read port.
module rrace_slot_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/rect_region_add_cut_engine_core.sv
// Top level of the rectangle region engine: sequencer over slot and piece memories.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | func, rectangle, shifts
//  out     | output    | out_valid_o/stall_i| piece, hit, last, overflow, used_count
//
// An add, cut, query or move scans every slot through the slot memory, each slot in
// a read state then an evaluate/write state; a slot freed by a cut or add first steps
// through its four candidate leftover pieces, buffering those it needs. Each buffered
// piece is then read back and inserted, then the add's own rectangle, then the result
// is loaded; the next transaction is taken the cycle after the result is loaded.
// The input stalls from acceptance until the result is loaded. A query stalls its scan
// on a second hit while the output register is still full; the final result waits on
// out_stall_i. Reset clears valid bits, fill pointer and control; memories are not cleared.
module rect_region_add_cut_engine_core #(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            func_i,
  input  logic [COORD_BITS-1:0] left_i,
  input  logic [COORD_BITS-1:0] top_i,
  input  logic [COORD_BITS-1:0] right_i,
  input  logic [COORD_BITS-1:0] bottom_i,
  input  logic [COORD_BITS-1:0] shift_x_i,
  input  logic [COORD_BITS-1:0] shift_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] piece_left_o,
  output logic [COORD_BITS-1:0] piece_top_o,
  output logic [COORD_BITS-1:0] piece_right_o,
  output logic [COORD_BITS-1:0] piece_bottom_o,
  output logic                  hit_o,
  output logic                  last_o,
  output logic                  overflow_o,
  output logic [5:0]            used_count_o
);
  import rrace_pkg::*;

  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned PD   = 4 * SLOTS;
  localparam int unsigned PW   = $clog2(PD);
  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned RW   = 4 * CB;
  localparam int unsigned CNTW = $clog2(SLOTS + 1);

  // ---------------- registers ----------------
  state_e            state_q, state_d;
  logic [2:0]        func_q;
  logic [CB-1:0]     pl_q, pt_q, pr_q, pb_q, dx_q, dy_q;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [SW-1:0]     fill_q, fill_d;
  logic [SW-1:0]     idx_q, idx_d;       // scan index
  logic [PW:0]       pcnt_q, pcnt_d;     // buffered piece count
  logic [PW:0]       pidx_q, pidx_d;     // piece being inserted
  logic [2:0]        sub_q, sub_d;       // piece emission sub-step within a slot
  logic              ovf_q, ovf_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              hold_q, hold_d;     // a query hit waits for the next one or the end
  logic [RW-1:0]     hrect_q, hrect_d;
  logic              ov_q, ov_d;
  logic [RW-1:0]     orect_q, orect_d;
  logic              ohit_q, ohit_d, olast_q, olast_d, oovf_q, oovf_d;
  logic [CNTW-1:0]   ocnt_q, ocnt_d;
  logic              oload;

  // ---------------- memories ----------------
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [RW-1:0] s_wdata, s_rdata;

  rrace_slot_mem #(.DEPTH(SLOTS), .WIDTH(RW)) u_slot_mem (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  logic          p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [RW-1:0] p_wdata, p_rdata;

  rrace_slot_mem #(.DEPTH(PD), .WIDTH(RW)) u_pend_mem (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  // ---------------- overlap of slot read data with operand ----------------
  logic signed [CB-1:0] al, at, ar, ab, ol, ot, orr, ob;
  logic                 ovl;
  always_comb begin
    al  = s_rdata[RW-1 -: CB];
    at  = s_rdata[3*CB-1 -: CB];
    ar  = s_rdata[2*CB-1 -: CB];
    ab  = s_rdata[CB-1:0];
    ol  = (al > $signed(pl_q)) ? al : $signed(pl_q);
    ot  = (at > $signed(pt_q)) ? at : $signed(pt_q);
    orr = (ar < $signed(pr_q)) ? ar : $signed(pr_q);
    ob  = (ab < $signed(pb_q)) ? ab : $signed(pb_q);
    ovl = (ol <= orr) && (ot <= ob);
  end

  // leftover pieces of the current slot, top/bottom/left/right
  logic [3:0]    pneed;
  logic [RW-1:0] pc [4];
  always_comb begin
    pneed[0] = (at != ot);
    pneed[1] = (ab != ob);
    pneed[2] = (al != ol);
    pneed[3] = (ar != orr);
    pc[0] = {al, at, ar, CB'(ot - CB'(1))};
    pc[1] = {al, CB'(ob + CB'(1)), ar, ab};
    pc[2] = {al, ot, CB'(ol - CB'(1)), ob};
    pc[3] = {CB'(orr + CB'(1)), ot, ar, ob};
  end

  // first free slot at or after the fill pointer, else the lowest free slot
  logic          free_any;
  logic [SW-1:0] free_idx, free_nx;
  always_comb begin
    free_any = |(~valid_q);
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = SW'(i);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i] && (SW'(i) >= fill_q)) free_idx = SW'(i);
    end
  end
  assign free_nx = (free_idx == SW'(SLOTS - 1)) ? '0 : free_idx + SW'(1);

  logic in_acc, out_acc, out_free;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = ov_q && !out_stall_i;
  assign out_free   = !ov_q || !out_stall_i;

  logic is_cut;
  assign is_cut = (func_q == FUNC_ADD) || (func_q == FUNC_CUT);

  logic [SW-1:0] idx_nx;
  state_e        scan_nx;
  assign idx_nx  = (idx_q == SW'(SLOTS - 1)) ? '0 : idx_q + SW'(1);
  assign scan_nx = (idx_q == SW'(SLOTS - 1)) ? ST_PEND_RD : ST_SCAN_RD;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    pcnt_d  = pcnt_q;
    pidx_d  = pidx_q;
    sub_d   = sub_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    hrect_d = hrect_q;
    oload   = 1'b0;
    orect_d = '0;
    ohit_d  = 1'b0;
    olast_d = 1'b1;
    oovf_d  = 1'b0;
    ocnt_d  = cnt_q;
    s_we = 1'b0; s_waddr = idx_q; s_wdata = '0; s_raddr = idx_q;
    p_we = 1'b0; p_waddr = pcnt_q[PW-1:0]; p_wdata = pc[0]; p_raddr = pidx_q[PW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0; pcnt_d = '0; pidx_d = '0; ovf_d = 1'b0; sub_d = '0; hold_d = 1'b0;
          if (func_i == FUNC_PURGE) begin
            valid_d = '0; fill_d = '0; cnt_d = '0;
            state_d = ST_DONE;
          end else if (func_i > FUNC_PURGE) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        sub_d   = '0;
        state_d = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        if (!valid_q[idx_q] || (func_q != FUNC_MOVE && !ovl)) begin
          state_d = scan_nx;
          idx_d   = idx_nx;
        end else if (func_q == FUNC_MOVE) begin
          s_we    = 1'b1;
          s_wdata = {CB'(al + dx_q), CB'(at + dy_q), CB'(ar + dx_q), CB'(ab + dy_q)};
          state_d = scan_nx;
          idx_d   = idx_nx;
        end else if (func_q == FUNC_QUERY) begin
          // keep one hit back so the final one can carry last
          if (!hold_q) begin
            hold_d  = 1'b1;
            hrect_d = {ol, ot, orr, ob};
            state_d = scan_nx;
            idx_d   = idx_nx;
          end else if (out_free) begin
            oload   = 1'b1; orect_d = hrect_q; ohit_d = 1'b1; olast_d = 1'b0;
            hrect_d = {ol, ot, orr, ob};
            state_d = scan_nx;
            idx_d   = idx_nx;
          end
        end else begin
          // cut or add: check one leftover piece per cycle and buffer it if needed, then free the slot
          if (sub_q < 3'd4) begin
            if (pneed[sub_q[1:0]] && pcnt_q < (PW+1)'(PD)) begin
              p_we    = 1'b1;
              p_wdata = pc[sub_q[1:0]];
              pcnt_d  = pcnt_q + (PW+1)'(1);
            end
            sub_d = sub_q + 3'd1;
          end else begin
            valid_d[idx_q] = 1'b0;
            cnt_d   = cnt_q - CNTW'(1);
            state_d = scan_nx;
            idx_d   = idx_nx;
          end
        end
      end
      ST_PEND_RD: begin
        if (func_q == FUNC_QUERY) begin
          state_d = ST_QOUT;
        end else if (!is_cut) begin
          state_d = ST_DONE;
        end else if (pidx_q < pcnt_q) begin
          state_d = ST_INS_SRCH;
        end else if (func_q == FUNC_ADD) begin
          state_d = ST_INS_SELF;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_INS_SRCH, ST_INS_SELF: begin
        s_wdata = (state_q == ST_INS_SRCH) ? p_rdata : {pl_q, pt_q, pr_q, pb_q};
        s_waddr = free_idx;
        if (free_any) begin
          s_we = 1'b1;
          valid_d[free_idx] = 1'b1;
          cnt_d  = cnt_q + CNTW'(1);
          fill_d = free_nx;
        end else begin
          ovf_d = 1'b1;
        end
        if (state_q == ST_INS_SRCH) begin
          pidx_d  = pidx_q + (PW+1)'(1);
          state_d = ST_PEND_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_QOUT: begin
        if (out_free) begin
          oload   = 1'b1;
          orect_d = hold_q ? hrect_q : '0;
          ohit_d  = hold_q;
          hold_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          oload   = 1'b1;
          oovf_d  = is_cut ? ovf_q : 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    ov_d = oload ? 1'b1 : (out_acc ? 1'b0 : ov_q);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      pcnt_q  <= '0;
      pidx_q  <= '0;
      sub_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      hold_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      pcnt_q  <= pcnt_d;
      pidx_q  <= pidx_d;
      sub_q   <= sub_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      pl_q <= left_i;  pt_q <= top_i;  pr_q <= right_i;  pb_q <= bottom_i;
      dx_q <= shift_x_i; dy_q <= shift_y_i;
    end
    hrect_q <= hrect_d;
    if (oload) begin
      orect_q <= orect_d; ohit_q <= ohit_d; olast_q <= olast_d; oovf_q <= oovf_d;
      ocnt_q  <= ocnt_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign piece_left_o   = orect_q[RW-1 -: CB];
  assign piece_top_o    = orect_q[3*CB-1 -: CB];
  assign piece_right_o  = orect_q[2*CB-1 -: CB];
  assign piece_bottom_o = orect_q[CB-1:0];
  assign hit_o          = ohit_q;
  assign last_o         = olast_q;
  assign overflow_o     = oovf_q;
  assign used_count_o   = 6'(ocnt_q);

`ifndef SYNTH
  // the occupied count tracks the valid bits
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNTW'($countones(valid_q))) else $error("used count mismatch");
  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable({orect_q, ohit_q, olast_q, oovf_q, ocnt_q})))
    else $error("stalled result changed");
  // a hit result never carries overflow
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> !overflow_o) else $error("hit with overflow");
`endif

endmodule
